### hdl/rdq_pkg.sv
// shared constants and types for the reversible deque
// no dependencies
`default_nettype none

package rdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int OUT_TDATA_W   = 72;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_REVERSE    = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                rev;
        logic                empty;
        logic                full;
    } rdq_info_t;

endpackage

`default_nettype wire

### hdl/rdq_mem.sv
// entry storage: one write port, two registered read ports
// depends on rdq_pkg
`default_nettype none

module rdq_mem #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [rdq_pkg::WORD_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr_a,
    input  wire logic [AW-1:0]              rd_addr_b,
    output logic      [rdq_pkg::WORD_W-1:0] rd_data_a,
    output logic      [rdq_pkg::WORD_W-1:0] rd_data_b
);
    import rdq_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

### hdl/rdq_ctrl.sv
// ring pointers, occupancy and reverse flag; decodes each item into
// a memory write and the read addresses of both ends. depends on rdq_pkg
`default_nettype none

module rdq_ctrl #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [rdq_pkg::OP_W-1:0]    opcode,
    output logic                             wr_en,
    output logic      [AW-1:0]               wr_addr,
    output logic      [AW-1:0]               start_addr,
    output logic      [AW-1:0]               end_addr,
    output rdq_pkg::rdq_info_t               info
);
    import rdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

    logic [AW-1:0] first_reg, first_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic          rev_reg, rev_next;

    logic [SW-1:0] old_sum, new_sum;
    logic [AW-1:0] old_tail, new_tail;
    logic [AW-1:0] first_dec, first_inc;
    logic          full_now, empty_now;
    logic [STATUS_W-1:0] status;

    always_comb
    begin
        old_sum  = SW'(first_reg) + SW'(occ_reg);
        old_tail = (old_sum >= DEPTH_S) ? AW'(old_sum - DEPTH_S) : AW'(old_sum);
        first_dec = (first_reg == '0) ? LAST_SLOT : first_reg - AW'(1);
        first_inc = (first_reg == LAST_SLOT) ? '0 : first_reg + AW'(1);
        full_now  = (occ_reg == FULL_CNT);
        empty_now = (occ_reg == '0);

        first_next = first_reg;
        occ_next   = occ_reg;
        rev_next   = rev_reg;
        wr_en      = 1'b0;
        wr_addr    = old_tail;
        status     = ST_OK;

        unique case (opcode) inside
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (full_now)
                begin
                    status = ST_PUSH_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    occ_next = occ_reg + CW'(1);
                    if ((opcode == OP_PUSH_BACK) != rev_reg)
                    begin
                        wr_addr = old_tail;
                    end
                    else
                    begin
                        wr_addr    = first_dec;
                        first_next = first_dec;
                    end
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (empty_now)
                begin
                    status = ST_POP_EMPTY;
                end
                else
                begin
                    occ_next = occ_reg - CW'(1);
                    if ((opcode == OP_POP_FRONT) != rev_reg)
                    begin
                        first_next = first_inc;
                    end
                end
            end
            OP_REVERSE:
            begin
                rev_next = ~rev_reg;
            end
            default:
            begin
            end
        endcase

        // end slot of the ring after the operation
        new_sum  = SW'(first_next) + SW'(occ_next);
        new_tail = (new_sum >= DEPTH_S) ? AW'(new_sum - DEPTH_S) : AW'(new_sum);
        end_addr   = (new_tail == '0) ? LAST_SLOT : new_tail - AW'(1);
        start_addr = first_next;

        info.status = status;
        info.rev    = rev_next;
        info.empty  = (occ_next == '0);
        info.full   = (occ_next == FULL_CNT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            occ_reg   <= '0;
            rev_reg   <= 1'b0;
        end
        else if (accept)
        begin
            first_reg <= first_next;
            occ_reg   <= occ_next;
            rev_reg   <= rev_next;
        end
    end

endmodule

`default_nettype wire

### hdl/reversible_deque.sv
// reversible deque top level: stream handshake, read stage and output register
// depends on rdq_pkg, rdq_ctrl, rdq_mem
//
// usage
//   each input item carries an opcode in s_axis_tuser and a word in s_axis_tdata:
//   push back, push front, pop back, pop front, reverse or peek
//   each input item gives exactly one output item on the m_axis channel with the
//   front and back words after the operation (-1 when empty), the empty and full
//   flags and a status code (ok, pop on empty ignored, push on full dropped)
//   the accepting edge updates the pointers, writes the ring and reads both ends into
//   the read stage; the output register loads from the read stage when it advances
//   throughput: one item per cycle while the output is not stalled; the memory writes
//   at one port and reads both ends of the ring at two ports for each accepted item,
//   with a same-cycle write forwarded to the read stage
//   reset: queue empty, reverse flag clear, no item in flight; stored words
//   need no clearing since only occupied slots are ever shown at the output
//   stall: while m_axis_tready is low the output item holds, the read stage
//   holds one more item, and s_axis_tready drops once both are occupied
`default_nettype none

module reversible_deque #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // value
    input  wire logic [rdq_pkg::WORD_W-1:0]      s_axis_tdata,
    // opcode
    input  wire logic [rdq_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // front_value, back_value, is_empty, is_full, status, zero pad
    output logic      [rdq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rdq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr, start_addr, end_addr;
    rdq_info_t     info;
    logic [WORD_W-1:0] rd_start, rd_end;

    logic              s1_valid_reg;
    rdq_info_t         s1_info_reg;
    logic              s1_fwd_start_reg, s1_fwd_end_reg;
    logic [WORD_W-1:0] s1_word_reg;
    logic              s1_advance;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [WORD_W-1:0] start_word, end_word, front_word, back_word;

    assign s1_advance    = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    rdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (s_axis_tuser),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .start_addr (start_addr),
        .end_addr   (end_addr),
        .info       (info)
    );

    rdq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en && accept),
        .wr_addr   (wr_addr),
        .wr_data   (s_axis_tdata),
        .rd_en     (accept),
        .rd_addr_a (start_addr),
        .rd_addr_b (end_addr),
        .rd_data_a (rd_start),
        .rd_data_b (rd_end)
    );

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg      <= info;
            s1_word_reg      <= s_axis_tdata;
            s1_fwd_start_reg <= wr_en && (wr_addr == start_addr);
            s1_fwd_end_reg   <= wr_en && (wr_addr == end_addr);
        end
    end

    always_comb
    begin
        start_word = s1_fwd_start_reg ? s1_word_reg : rd_start;
        end_word   = s1_fwd_end_reg ? s1_word_reg : rd_end;
        if (s1_info_reg.empty)
        begin
            front_word = '1;
            back_word  = '1;
        end
        else if (s1_info_reg.rev)
        begin
            front_word = end_word;
            back_word  = start_word;
        end
        else
        begin
            front_word = start_word;
            back_word  = end_word;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_data_reg <= {4'b0000, s1_info_reg.status, s1_info_reg.full,
                             s1_info_reg.empty, back_word, front_word};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

### hdl/rdq_checker.sv
// port-level checks for the reversible deque and their bind to the top level
// depends on rdq_pkg and reversible_deque
`default_nettype none

module rdq_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [rdq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rdq_pkg::*;

    logic [WORD_W-1:0]   front_w, back_w;
    logic                empty_f, full_f;
    logic [STATUS_W-1:0] status_f;

    assign front_w  = m_axis_tdata[31:0];
    assign back_w   = m_axis_tdata[63:32];
    assign empty_f  = m_axis_tdata[64];
    assign full_f   = m_axis_tdata[65];
    assign status_f = m_axis_tdata[67:66];

    // stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // empty queue reads -1 at both ends
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && empty_f |-> front_w == '1 && back_w == '1)
        else $error("empty queue shows a word");

    // dropped push only when full, ignored pop only when empty
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status_f == ST_PUSH_FULL |-> full_f && !empty_f)
        else $error("push dropped on a queue that is not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status_f == ST_POP_EMPTY |-> empty_f && !full_f)
        else $error("pop ignored on a queue that is not empty");

    // status is one of the three defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !(status_f == ST_OK || status_f == ST_POP_EMPTY
                           || status_f == ST_PUSH_FULL) |-> 1'b0)
        else $error("undefined status code");

endmodule

bind reversible_deque rdq_checker u_rdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### bench/reversible_deque_tb.sv
// testbench for reversible_deque: directed end cases, randomized push/pop traffic under
// sender and receiver idling, and a long output hold-off that fills the pipeline
// depends on rdq_pkg and reversible_deque
`timescale 1ns / 100ps

module reversible_deque_tb;

    import rdq_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int HOLD_CYCLES = 64;

    // unused opcodes, handled like a peek
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] WORD_ZERO = 32'h0000_0000;
    localparam logic [WORD_W-1:0] WORD_ONE  = 32'h0000_0001;
    localparam logic [WORD_W-1:0] WORD_NEG1 = 32'hffff_ffff;

    typedef struct packed {
        logic [WORD_W-1:0]   front;
        logic [WORD_W-1:0]   back;
        logic                empty;
        logic                full;
        logic [STATUS_W-1:0] status;
    } deque_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [WORD_W-1:0]      s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int error_count  = 0;
    logic hold_req   = 1'b0;
    logic hold_ack   = 1'b0;
    int hold_left    = 0;

    deque_result_t pending_results[$];

    // predictor state
    logic [WORD_W-1:0] ring_words[DEPTH];
    int                ring_head  = 0;
    int                ring_count = 0;
    logic              ring_rev   = 1'b0;

    reversible_deque #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic deque_model_step(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                                    output deque_result_t res);
        logic [STATUS_W-1:0] st;
        logic [WORD_W-1:0]   start_word;
        logic [WORD_W-1:0]   end_word;
        st = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (ring_count == DEPTH)
                    st = ST_PUSH_FULL;
                else if ((op == OP_PUSH_BACK) == !ring_rev)
                begin
                    ring_words[(ring_head + ring_count) % DEPTH] = word;
                    ring_count++;
                end
                else
                begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_words[ring_head] = word;
                    ring_count++;
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (ring_count == 0)
                    st = ST_POP_EMPTY;
                else if ((op == OP_POP_BACK) == !ring_rev)
                    ring_count--;
                else
                begin
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                end
            end
            OP_REVERSE:
                ring_rev = !ring_rev;
            default:
                ;
        endcase
        res.front = WORD_NEG1;
        res.back  = WORD_NEG1;
        if (ring_count != 0)
        begin
            start_word = ring_words[ring_head];
            end_word   = ring_words[(ring_head + ring_count - 1) % DEPTH];
            res.front  = ring_rev ? end_word : start_word;
            res.back   = ring_rev ? start_word : end_word;
        end
        res.empty  = (ring_count == 0);
        res.full   = (ring_count == DEPTH);
        res.status = st;
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
        int gap;
        deque_result_t res;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        deque_model_step(op, word, res);
        pending_results.insert(pending_results.size(), res);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        if ($urandom_range(0, 7) != 0)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return WORD_ZERO;
            3:       return WORD_ONE;
            default: return WORD_NEG1;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int push_w, input int pop_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_w)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        if (r < push_w + pop_w)
            return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        if (r < 94)
            return OP_REVERSE;
        if (r < 98)
            return OP_PEEK;
        return $urandom_range(0, 1) ? OP_SPARE7 : OP_SPARE6;
    endfunction

    task automatic test_basic_ops();
        send_op(OP_PEEK, WORD_MAX);
        send_op(OP_POP_BACK, WORD_ZERO);
        send_op(OP_POP_FRONT, WORD_ZERO);
        send_op(OP_REVERSE, WORD_ZERO);
        send_op(OP_PUSH_BACK, WORD_MAX);
        send_op(OP_REVERSE, WORD_ZERO);
        send_op(OP_PUSH_BACK, WORD_MIN);
        send_op(OP_PUSH_FRONT, WORD_ZERO);
        send_op(OP_PUSH_FRONT, WORD_NEG1);
        send_op(OP_SPARE6, WORD_ONE);
        send_op(OP_SPARE7, WORD_ONE);
        send_op(OP_REVERSE, WORD_MAX);
        send_op(OP_PUSH_BACK, WORD_ONE);
        send_op(OP_POP_FRONT, WORD_MAX);
        send_op(OP_PEEK, WORD_ZERO);
        send_op(OP_POP_BACK, WORD_MIN);
        send_op(OP_REVERSE, WORD_ZERO);
        send_op(OP_POP_BACK, WORD_ZERO);
        send_op(OP_POP_FRONT, WORD_ZERO);
        send_op(OP_POP_FRONT, WORD_ZERO);
        send_op(OP_POP_BACK, WORD_ZERO);
    endtask

    task automatic test_full_and_empty();
        int i;
        for (i = 0; i < DEPTH; i++)
            send_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, random_word());
        send_op(OP_PUSH_BACK, WORD_MAX);
        send_op(OP_PUSH_FRONT, WORD_MIN);
        send_op(OP_REVERSE, WORD_ZERO);
        send_op(OP_PUSH_FRONT, WORD_ONE);
        for (i = 0; i < DEPTH; i++)
            send_op(i[0] ? OP_POP_FRONT : OP_POP_BACK, random_word());
        send_op(OP_POP_FRONT, WORD_ZERO);
        send_op(OP_POP_BACK, WORD_ZERO);
        send_op(OP_REVERSE, WORD_ZERO);
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_idle, input int rx_stall);
        int i;
        int push_w;
        int pop_w;
        tx_idle_pct = tx_idle;
        rx_stall_pct <= rx_stall;
        push_w = 42;
        pop_w  = 42;
        for (i = 0; i < n_items; i++)
        begin
            // drift between filling, draining and balanced stretches
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        push_w = 65;
                        pop_w  = 20;
                    end
                    1:
                    begin
                        push_w = 20;
                        pop_w  = 65;
                    end
                    default:
                    begin
                        push_w = 42;
                        pop_w  = 42;
                    end
                endcase
            end
            send_op(pick_op(push_w, pop_w), random_word());
        end
    endtask

    task automatic test_output_backpressure();
        int i;
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        hold_req <= ~hold_req;
        for (i = 0; i < 40; i++)
            send_op(pick_op(70, 20), random_word());
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_req != hold_ack)
        begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    function automatic void check_field(input string name, input logic [WORD_W-1:0] expected_val,
                                        input logic [WORD_W-1:0] actual_val);
        if (actual_val !== expected_val)
        begin
            $error("%s: expected %h, actual %h", name, expected_val, actual_val);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        deque_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no operation pending: %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("front_value", want.front, m_axis_tdata[31:0]);
                check_field("back_value", want.back, m_axis_tdata[63:32]);
                check_field("is_empty", WORD_W'(want.empty), WORD_W'(m_axis_tdata[64]));
                check_field("is_full", WORD_W'(want.full), WORD_W'(m_axis_tdata[65]));
                check_field("status", WORD_W'(want.status), WORD_W'(m_axis_tdata[67:66]));
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_full_and_empty();
        test_random_traffic(400, 0, 0);
        test_random_traffic(350, 60, 0);
        test_random_traffic(350, 0, 60);
        test_output_backpressure();
        test_random_traffic(350, 22, 22);
        s_axis_tvalid <= 1'b0;
        rx_stall_pct <= 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("reversible_deque_tb: done, clean");
        else
            $display("reversible_deque_tb: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("reversible_deque_tb: done, errors");
        $finish;
    end

endmodule
